[src/assert_macros.svh]
// ---------------------------------------------------------------------------
// Assertion macros
// Shared clocked assertion wrappers; compiled out when ASSERT_OFF is set.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// prop must hold at every clock edge outside reset
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// expr must never be true outside reset
`define ASSERT_NEVER(label, clk, rst_n, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error(msg);

`else

`define ASSERT_CLK(label, clk, rst_n, prop, msg)

`define ASSERT_NEVER(label, clk, rst_n, expr, msg)

`endif

`endif

[src/lcdns_pkg.sv]
// ---------------------------------------------------------------------------
// lcdns_pkg
// Types, codes and constant tables for the LCD nibble sequencer.
// ---------------------------------------------------------------------------
package lcdns_pkg;

    localparam int ROW_LENGTH  = 40;

    // job queue between front end and back end
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    // stream widths
    localparam int S_TDATA_W = 24;
    localparam int S_TUSER_W = 2;
    localparam int M_TDATA_W = 40;
    localparam int M_TUSER_W = 1;

    // request kinds (s_tuser)
    localparam logic [1:0] CMD_INIT = 2'd0;
    localparam logic [1:0] CMD_CHAR = 2'd1;
    localparam logic [1:0] CMD_POS  = 2'd2;
    localparam logic [1:0] CMD_OP   = 2'd3;

    // named display commands
    localparam logic [2:0] OP_CLEAR       = 3'd0;
    localparam logic [2:0] OP_CURSOR_OFF  = 3'd1;
    localparam logic [2:0] OP_UNDERLINE   = 3'd2;
    localparam logic [2:0] OP_BLINK       = 3'd3;
    localparam logic [2:0] OP_FIRST_ROW   = 3'd4;
    localparam logic [2:0] OP_CURSOR_LEFT = 3'd5;
    localparam logic [2:0] OP_SECOND_ROW  = 3'd6;

    // pause classes carried by a job
    localparam logic [1:0] WCODE_SHORT = 2'd0;
    localparam logic [1:0] WCODE_CLEAR = 2'd1;
    localparam logic [1:0] WCODE_CHAR  = 2'd2;

    // waits in microseconds
    localparam logic [14:0] WAIT_POWERUP = 15'd20000;
    localparam logic [13:0] WAIT_SHORT   = 14'd200;
    localparam logic [13:0] WAIT_CLEAR   = 14'd2000;
    localparam logic [13:0] WAIT_CHAR    = 14'd10000;
    localparam logic [13:0] WAIT_FIRST   = 14'd5000;

    // DDRAM address bases
    localparam logic [7:0] ADDR_ROW1 = 8'h80;
    localparam logic [7:0] ADDR_ROW2 = 8'hC0;

    // init walks nine bytes, two strobes each
    localparam int INIT_BYTES = 9;
    localparam int STEP_W     = $clog2(2 * INIT_BYTES);
    localparam int BYTE_IDX_W = STEP_W - 1;

    typedef struct packed {
        logic       init;   // run the power-up sequence, ignore the rest
        logic       rs;     // register select for both strobes
        logic [7:0] data;   // byte to send
        logic [1:0] wcode;  // pause class after the lower nibble
    } job_t;

    typedef struct packed {
        logic                   full;
        logic                   empty;
        logic [QUEUE_CNT_W-1:0] count;
    } qstat_t;

    function automatic logic [7:0] init_byte(input logic [BYTE_IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            4'd0:    b = 8'h03;
            4'd1:    b = 8'h03;
            4'd2:    b = 8'h03;
            4'd3:    b = 8'h02;
            4'd4:    b = 8'h28;
            4'd5:    b = 8'h08;
            4'd6:    b = 8'h01;
            4'd7:    b = 8'h06;
            default: b = 8'h0C;
        endcase
        return b;
    endfunction

    function automatic logic [13:0] init_wait(input logic [BYTE_IDX_W-1:0] idx);
        logic [13:0] w;
        case (idx)
            4'd0:    w = WAIT_FIRST;
            4'd6:    w = WAIT_CLEAR;
            default: w = WAIT_SHORT;
        endcase
        return w;
    endfunction

    function automatic logic [7:0] op_byte(input logic [2:0] op);
        logic [7:0] b;
        case (op)
            OP_CLEAR:       b = 8'h01;
            OP_CURSOR_OFF:  b = 8'h0C;
            OP_UNDERLINE:   b = 8'h0E;
            OP_BLINK:       b = 8'h0D;
            OP_FIRST_ROW:   b = ADDR_ROW1;
            OP_CURSOR_LEFT: b = 8'h04;
            default:        b = ADDR_ROW2;  // second row, and the unused code
        endcase
        return b;
    endfunction

    function automatic logic [13:0] wait_value(input logic [1:0] code);
        logic [13:0] w;
        case (code)
            WCODE_CLEAR: w = WAIT_CLEAR;
            WCODE_CHAR:  w = WAIT_CHAR;
            default:     w = WAIT_SHORT;
        endcase
        return w;
    endfunction

endpackage

[src/lcdns_front.sv]
// ---------------------------------------------------------------------------
// lcdns_front
// Accepts requests and turns each into one job for the strobe back end.
// ---------------------------------------------------------------------------
module lcdns_front (
    input  logic                                s_tvalid,
    output logic                                s_tready,
    input  logic [lcdns_pkg::S_TDATA_W-1:0]     s_tdata,
    input  logic [lcdns_pkg::S_TUSER_W-1:0]     s_tuser,
    input  lcdns_pkg::qstat_t                   q_stat,
    output logic                                push,
    output lcdns_pkg::job_t                     push_job
);
    import lcdns_pkg::*;

    logic [7:0] char_code;
    logic [1:0] row;
    logic [5:0] column;
    logic [2:0] lcd_op;
    logic [5:0] col_sat;
    logic [7:0] pos_addr;

    assign char_code = s_tdata[7:0];
    assign row       = s_tdata[9:8];
    assign column    = s_tdata[15:10];
    assign lcd_op    = s_tdata[18:16];

    assign s_tready = !q_stat.full;
    assign push     = s_tvalid && s_tready;

    // clamp column to 1..ROW_LENGTH
    always_comb begin
        if (column == 6'd0) begin
            col_sat = 6'd1;
        end else if (column > 6'(ROW_LENGTH)) begin
            col_sat = 6'(ROW_LENGTH);
        end else begin
            col_sat = column;
        end
    end

    assign pos_addr = ((row == 2'd1) ? ADDR_ROW1 : ADDR_ROW2) + {2'b00, col_sat - 6'd1};

    always_comb begin
        push_job = '0;
        case (s_tuser)
            CMD_INIT: begin
                push_job.init = 1'b1;
            end
            CMD_CHAR: begin
                push_job.rs    = 1'b1;
                push_job.data  = char_code;
                push_job.wcode = WCODE_CHAR;
            end
            CMD_POS: begin
                push_job.data  = pos_addr;
                push_job.wcode = WCODE_SHORT;
            end
            default: begin
                push_job.data  = op_byte(lcd_op);
                push_job.wcode = (lcd_op == OP_CLEAR) ? WCODE_CLEAR : WCODE_SHORT;
            end
        endcase
    end

endmodule

[src/lcdns_queue.sv]
// ---------------------------------------------------------------------------
// lcdns_queue
// Small job FIFO that decouples request intake from strobe output.
// ---------------------------------------------------------------------------
module lcdns_queue (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  lcdns_pkg::job_t    push_job,
    input  logic               pop,
    output lcdns_pkg::job_t    pop_job,
    output lcdns_pkg::qstat_t  stat
);
    import lcdns_pkg::*;

    job_t                   entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg, count_next;

    function automatic logic [QUEUE_PTR_W-1:0] ptr_inc(input logic [QUEUE_PTR_W-1:0] p);
        return (p == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    assign pop_job    = entry_reg[rd_ptr_reg];
    assign stat.count = count_reg;
    assign stat.full  = (count_reg == QUEUE_CNT_W'(QUEUE_DEPTH));
    assign stat.empty = (count_reg == '0);

    always_comb begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

[src/lcdns_back.sv]
// ---------------------------------------------------------------------------
// lcdns_back
// Walks the current job one strobe per cycle into the output register while m_tready does not hold it.
// ---------------------------------------------------------------------------
module lcdns_back (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lcdns_pkg::job_t                     q_job,
    input  lcdns_pkg::qstat_t                   q_stat,
    output logic                                pop,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [lcdns_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic [lcdns_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                                m_tlast
);
    import lcdns_pkg::*;

    logic                  cur_valid_reg, cur_valid_next;
    job_t                  cur_job_reg;
    logic [STEP_W-1:0]     step_reg, step_next;

    logic                  m_valid_reg, m_valid_next;
    logic                  m_rs_reg;
    logic [3:0]            m_nibble_reg;
    logic [14:0]           m_before_reg;
    logic [13:0]           m_after_reg;
    logic                  m_last_reg;

    logic [BYTE_IDX_W-1:0] byte_idx;
    logic                  upper;
    logic [7:0]            byte_val;
    logic [3:0]            nibble;
    logic [14:0]           wait_before;
    logic [13:0]           wait_after;
    logic                  strobe_last;
    logic                  load;

    assign byte_idx = step_reg[STEP_W-1:1];
    assign upper    = !step_reg[0];
    assign byte_val = cur_job_reg.init ? init_byte(byte_idx) : cur_job_reg.data;
    assign nibble   = upper ? byte_val[7:4] : byte_val[3:0];

    assign wait_before = (cur_job_reg.init && step_reg == '0) ? WAIT_POWERUP : '0;
    assign wait_after  = upper ? '0 :
                         (cur_job_reg.init ? init_wait(byte_idx) : wait_value(cur_job_reg.wcode));
    assign strobe_last = !upper &&
                         (!cur_job_reg.init || byte_idx == BYTE_IDX_W'(INIT_BYTES - 1));

    assign load = cur_valid_reg && (!m_valid_reg || m_tready);
    assign pop  = !q_stat.empty && (!cur_valid_reg || (load && strobe_last));

    always_comb begin
        cur_valid_next = cur_valid_reg;
        step_next      = step_reg;
        if (pop) begin
            cur_valid_next = 1'b1;
            step_next      = '0;
        end else if (load) begin
            if (strobe_last) begin
                cur_valid_next = 1'b0;
            end else begin
                step_next = step_reg + 1'b1;
            end
        end
        if (load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end else begin
            m_valid_next = m_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cur_valid_reg <= 1'b0;
            step_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            cur_valid_reg <= cur_valid_next;
            step_reg      <= step_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_job_reg <= q_job;
        end
        if (load) begin
            m_rs_reg     <= cur_job_reg.rs;
            m_nibble_reg <= nibble;
            m_before_reg <= wait_before;
            m_after_reg  <= wait_after;
            m_last_reg   <= strobe_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tuser  = m_rs_reg;
    assign m_tlast  = m_last_reg;
    assign m_tdata  = {7'b0, m_after_reg, m_before_reg, m_nibble_reg};

endmodule

[src/char_lcd_nibble_sequencer_core.sv]
// ---------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core - 4-bit character LCD strobe sequencer
// Latency: a request passes the job queue, current-job and output registers before its first strobe.
// Throughput: one strobe per cycle from the back end's single output register while m_tready holds,
// two strobes per char/position/command request and eighteen per init.
// Reset: synchronous aresetn clears queue and output valid.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module char_lcd_nibble_sequencer_core (
    input  logic                                aclk,
    input  logic                                aresetn,
    // request channel
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [7:0] char_code, [9:8] row, [15:10] column, [18:16] lcd_op, [23:19] zero
    input  logic [lcdns_pkg::S_TDATA_W-1:0]     s_tdata,
    // [1:0] cmd
    input  logic [lcdns_pkg::S_TUSER_W-1:0]     s_tuser,
    // strobe channel
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [3:0] nibble, [18:4] wait_before_us, [32:19] wait_after_us, [39:33] zero
    output logic [lcdns_pkg::M_TDATA_W-1:0]     m_tdata,
    // [0] reg_select
    output logic [lcdns_pkg::M_TUSER_W-1:0]     m_tuser,
    output logic                                m_tlast
);
    import lcdns_pkg::*;

    // front end -> queue
    logic   push;
    job_t   push_job;
    // queue -> back end
    logic   pop;
    job_t   pop_job;
    qstat_t q_stat;

    // Front end: decode request kind, clamp column, pick byte and pause class.
    // Stalls only when the job queue is full.
    lcdns_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    // Job FIFO: lets intake run ahead while the back end drains long init runs.
    lcdns_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .pop_job  (pop_job),
        .stat     (q_stat)
    );

    // Back end: upper nibble then lower nibble per byte, pause on the lower one.
    // Next job, if queued, is pulled in the same cycle the current one issues its last strobe.
    lcdns_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_job    (pop_job),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // queue occupancy never runs past its depth
    `ASSERT_NEVER(a_queue_bound, aclk, aresetn, q_stat.count > QUEUE_CNT_W'(QUEUE_DEPTH), "job queue overflow")

    // the power-up delay only rides on the first init strobe (instruction, upper nibble of 0x03)
    `ASSERT_CLK(a_powerup_strobe, aclk, aresetn, (m_tvalid && m_tdata[18:4] != 15'd0) |-> (m_tdata[3:0] == 4'd0 && !m_tuser[0] && !m_tlast), "power-up delay on wrong strobe")

    // every final strobe is a lower nibble and carries a pause
    `ASSERT_CLK(a_last_has_pause, aclk, aresetn, (m_tvalid && m_tlast) |-> (m_tdata[32:19] != 14'd0), "last strobe without pause")

endmodule

[bench/lcd_strobe_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lcd_strobe_checker
// Watches both stream channels of the LCD nibble sequencer. It expands each
// request transaction into the strobes it should produce and compares every
// strobe transaction, in order, against them.
// ---------------------------------------------------------------------------
module lcd_strobe_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    input  logic                            s_tready,
    // [7:0] char_code, [9:8] row, [15:10] column, [18:16] lcd_op, [23:19] zero
    input  logic [lcdns_pkg::S_TDATA_W-1:0] s_tdata,
    // [1:0] cmd
    input  logic [lcdns_pkg::S_TUSER_W-1:0] s_tuser,
    input  logic                            m_tvalid,
    input  logic                            m_tready,
    // [3:0] nibble, [18:4] wait_before_us, [32:19] wait_after_us, [39:33] zero
    input  logic [lcdns_pkg::M_TDATA_W-1:0] m_tdata,
    // [0] reg_select
    input  logic [lcdns_pkg::M_TUSER_W-1:0] m_tuser,
    input  logic                            m_tlast,
    output int                              fail_count,
    output int                              strobes_pending,
    output int                              requests_seen,
    output int                              inits_seen,
    output int                              strobes_seen
);
    import lcdns_pkg::*;

    localparam logic [14:0] POWER_UP_US  = 15'd20000;
    localparam logic [13:0] PAUSE_SHORT  = 14'd200;
    localparam logic [13:0] PAUSE_CLEAR  = 14'd2000;
    localparam logic [13:0] PAUSE_CHAR   = 14'd10000;
    localparam int          PRINT_LIMIT  = 40;

    // power-up bytes and their pauses, entry 0 in the low bits
    localparam logic [71:0] PWR_BYTES = {8'h0C, 8'h06, 8'h01, 8'h08, 8'h28,
                                         8'h02, 8'h03, 8'h03, 8'h03};
    localparam logic [125:0] PWR_PAUSE = {14'd200, 14'd200, 14'd2000, 14'd200,
                                          14'd200, 14'd200, 14'd200, 14'd200,
                                          14'd5000};
    // named display command bytes by lcd_op; the spare code acts as second row
    localparam logic [63:0] OP_BYTES = {8'hC0, 8'hC0, 8'h04, 8'h80,
                                        8'h0D, 8'h0E, 8'h0C, 8'h01};

    typedef struct packed {
        logic        rs;
        logic [3:0]  nib;
        logic [14:0] before_us;
        logic [13:0] after_us;
        logic        last;
    } strobe_t;

    strobe_t strobe_q[$];
    strobe_t want;
    int      fails    = 0;
    int      depth    = 0;
    int      requests = 0;
    int      inits    = 0;
    int      strobes  = 0;

    assign fail_count      = fails;
    assign strobes_pending = depth;
    assign requests_seen   = requests;
    assign inits_seen      = inits;
    assign strobes_seen    = strobes;

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want_v);
        if (fails < PRINT_LIMIT)
            $display("%0t ns: strobe %0d %s: got 0x%0h, want 0x%0h",
                     $time, strobes, what, got, want_v);
        fails++;
    endtask

    // upper nibble first, pause rides on the lower one
    task automatic push_byte(input logic rs, input logic [7:0] b,
                             input logic [14:0] before_us,
                             input logic [13:0] after_us, input logic last);
        strobe_q.push_back('{rs, b[7:4], before_us, 14'd0, 1'b0});
        strobe_q.push_back('{rs, b[3:0], 15'd0, after_us, last});
    endtask

    task automatic predict_strobes(input logic [1:0] cmd,
                                   input logic [S_TDATA_W-1:0] d);
        logic [5:0] col;
        logic [2:0] op;
        logic [7:0] addr;
        int         i;
        col = d[15:10];
        op  = d[18:16];
        case (cmd)
            CMD_INIT: begin
                for (i = 0; i < 9; i++)
                    push_byte(1'b0, PWR_BYTES[8*i +: 8],
                              (i == 0) ? POWER_UP_US : 15'd0,
                              PWR_PAUSE[14*i +: 14], i == 8);
            end
            CMD_CHAR: push_byte(1'b1, d[7:0], 15'd0, PAUSE_CHAR, 1'b1);
            CMD_POS: begin
                if (col == 6'd0)
                    col = 6'd1;
                if (col > ROW_LENGTH)
                    col = 6'(ROW_LENGTH);
                addr = ((d[9:8] == 2'd1) ? 8'h80 : 8'hC0) + {2'b00, col} - 8'd1;
                push_byte(1'b0, addr, 15'd0, PAUSE_SHORT, 1'b1);
            end
            default: begin
                push_byte(1'b0, OP_BYTES[8*op +: 8], 15'd0,
                          (op == OP_CLEAR) ? PAUSE_CLEAR : PAUSE_SHORT, 1'b1);
            end
        endcase
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            strobe_q.delete();
        end else begin
            if (s_tvalid && s_tready) begin
                predict_strobes(s_tuser[1:0], s_tdata);
                requests++;
                if (s_tuser[1:0] == CMD_INIT)
                    inits++;
            end
            if (m_tvalid && m_tready) begin
                if (strobe_q.size() == 0) begin
                    report_mismatch("arrived with nothing expected", m_tdata[31:0], 0);
                end else begin
                    want = strobe_q.pop_front();
                    if (m_tuser[0] !== want.rs)
                        report_mismatch("reg_select", m_tuser[0], want.rs);
                    if (m_tdata[3:0] !== want.nib)
                        report_mismatch("nibble", m_tdata[3:0], want.nib);
                    if (m_tdata[18:4] !== want.before_us)
                        report_mismatch("wait_before_us", m_tdata[18:4], want.before_us);
                    if (m_tdata[32:19] !== want.after_us)
                        report_mismatch("wait_after_us", m_tdata[32:19], want.after_us);
                    if (m_tlast !== want.last)
                        report_mismatch("last", m_tlast, want.last);
                end
                strobes++;
            end
        end
        depth = strobe_q.size();
    end

endmodule

[bench/char_lcd_nibble_sequencer_core_tb.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// char_lcd_nibble_sequencer_core_tb
// Drives init, character, position and display-command requests into the
// sequencer with random gaps and output stalls, including one long output
// hold-off, and leaves prediction and comparison to lcd_strobe_checker.
// ---------------------------------------------------------------------------
module char_lcd_nibble_sequencer_core_tb;
    import lcdns_pkg::*;

    localparam int CHOKE_CYCLES = 300;   // long receiver hold-off
    localparam int TAIL_CYCLES  = 16;    // drain margin for stray strobes once the backlog is empty

    logic                 aclk;
    logic                 aresetn;
    logic                 s_tvalid;
    logic                 s_tready;
    // [7:0] char_code, [9:8] row, [15:10] column, [18:16] lcd_op, [23:19] zero
    logic [S_TDATA_W-1:0] s_tdata;
    // [1:0] cmd
    logic [S_TUSER_W-1:0] s_tuser;
    logic                 m_tvalid;
    logic                 m_tready;
    // [3:0] nibble, [18:4] wait_before_us, [32:19] wait_after_us, [39:33] zero
    logic [M_TDATA_W-1:0] m_tdata;
    // [0] reg_select
    logic [M_TUSER_W-1:0] m_tuser;
    logic                 m_tlast;

    int   fail_count;
    int   strobes_pending;
    int   requests_seen;
    int   inits_seen;
    int   strobes_seen;

    // both sides stop idling while this is set
    logic burst_mode;
    // one-shot request for the long receiver hold-off
    logic choke_req;

    char_lcd_nibble_sequencer_core DUT (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    lcd_strobe_checker u_checker (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_tvalid        (s_tvalid),
        .s_tready        (s_tready),
        .s_tdata         (s_tdata),
        .s_tuser         (s_tuser),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_tdata         (m_tdata),
        .m_tuser         (m_tuser),
        .m_tlast         (m_tlast),
        .fail_count      (fail_count),
        .strobes_pending (strobes_pending),
        .requests_seen   (requests_seen),
        .inits_seen      (inits_seen),
        .strobes_seen    (strobes_seen)
    );

    // 8 ns clock
    initial aclk = 1'b0;
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // One request transaction. The gap before it is drawn per item; with no
    // gap, tvalid simply stays high and only the payload changes, so tvalid
    // never gets two updates in one time step.
    task automatic send_request(input logic [1:0] cmd, input logic [7:0] ch,
                                input logic [1:0] row, input logic [5:0] col,
                                input logic [2:0] op);
        int gap;
        gap = burst_mode ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tdata  <= {5'd0, op, col, row, ch};
        // s_tready read here is its value just before the edge
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
    endtask

    // Mix weighted toward short requests; init stays rare since it is 18
    // strobes long. Unused fields carry random junk on every request.
    task automatic send_random_request();
        int         pick;
        logic [1:0] cmd;
        logic [7:0] ch;
        logic [1:0] row;
        logic [5:0] col;
        logic [2:0] op;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            cmd = CMD_INIT;
        else if (pick < 45)
            cmd = CMD_CHAR;
        else if (pick < 75)
            cmd = CMD_POS;
        else
            cmd = CMD_OP;
        ch  = $urandom_range(0, 255);
        row = $urandom_range(0, 3);
        // mostly legal columns, now and then zero or past the row end
        if ($urandom_range(0, 7) == 0)
            col = $urandom_range(0, 63);
        else
            col = $urandom_range(1, ROW_LENGTH);
        op  = $urandom_range(0, 7);
        send_request(cmd, ch, row, col, op);
    endtask

    // Stimulus: reset, directed corners, then three random phases.
    initial begin
        int n;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tuser    = '0;
        burst_mode = 1'b0;
        choke_req  = 1'b0;
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        // power-up sequence with every unused field at its top value
        send_request(CMD_INIT, 8'hFF, 2'd3, 6'd63, 3'd7);
        // character extremes and alternating bit patterns
        send_request(CMD_CHAR, 8'h00, 2'd0, 6'd0,  3'd0);
        send_request(CMD_CHAR, 8'hFF, 2'd3, 6'd63, 3'd7);
        send_request(CMD_CHAR, 8'hA5, 2'd1, 6'd21, 3'd2);
        send_request(CMD_CHAR, 8'h5A, 2'd2, 6'd42, 3'd5);
        // cursor positions: first row at both ends, second row at its last column
        send_request(CMD_POS, 8'h00, 2'd1, 6'd1,  3'd0);
        send_request(CMD_POS, 8'hFF, 2'd2, 6'd40, 3'd7);
        send_request(CMD_POS, 8'h00, 2'd1, 6'd40, 3'd0);
        // column zero clamps to one, columns past the row end clamp to it
        send_request(CMD_POS, 8'h3C, 2'd1, 6'd0,  3'd6);
        send_request(CMD_POS, 8'hC3, 2'd2, 6'd63, 3'd1);
        send_request(CMD_POS, 8'h00, 2'd1, 6'd41, 3'd0);
        // row codes other than one land on the second row
        send_request(CMD_POS, 8'h00, 2'd0, 6'd7,  3'd0);
        send_request(CMD_POS, 8'h00, 2'd3, 6'd33, 3'd0);
        // every named command, plus the spare code
        send_request(CMD_OP, 8'hFF, 2'd3, 6'd63, OP_CLEAR);
        send_request(CMD_OP, 8'h00, 2'd0, 6'd0,  OP_CURSOR_OFF);
        send_request(CMD_OP, 8'h81, 2'd1, 6'd5,  OP_UNDERLINE);
        send_request(CMD_OP, 8'h7E, 2'd2, 6'd60, OP_BLINK);
        send_request(CMD_OP, 8'h11, 2'd1, 6'd1,  OP_FIRST_ROW);
        send_request(CMD_OP, 8'hEE, 2'd2, 6'd40, OP_CURSOR_LEFT);
        send_request(CMD_OP, 8'h33, 2'd0, 6'd12, OP_SECOND_ROW);
        send_request(CMD_OP, 8'hCC, 2'd3, 6'd50, 3'd7);
        // re-init after traffic
        send_request(CMD_INIT, 8'h00, 2'd0, 6'd0, 3'd0);

        // random traffic with gaps on both sides
        for (n = 0; n < 40; n++)
            send_random_request();

        // back-to-back traffic; the receiver freezes first, so the queue
        // fills and s_tready must drop while tvalid stays up
        burst_mode = 1'b1;
        choke_req  = 1'b1;
        for (n = 0; n < 34; n++)
            send_random_request();
        burst_mode = 1'b0;

        for (n = 0; n < 34; n++)
            send_random_request();
        s_tvalid <= 1'b0;

        // let the checker log the final request before looking at its backlog
        @(posedge aclk);
        // drain, then give the block time to emit anything stray
        while (strobes_pending != 0) @(posedge aclk);
        repeat (TAIL_CYCLES) @(posedge aclk);

        $display("Run covered %0d requests (%0d power-up sequences), %0d strobes compared,",
                 requests_seen, inits_seen, strobes_seen);
        $display("with random gaps and stalls, no-idle stretches and a %0d-cycle output hold.",
                 CHOKE_CYCLES);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Receiver: a fresh random stall per strobe transaction, none while
    // bursting. The long hold-off is timed here, independent of the sender.
    initial begin
        int stall;
        m_tready = 1'b0;
        @(posedge aclk);
        while (!aresetn) @(posedge aclk);
        forever begin
            if (choke_req) begin
                choke_req = 1'b0;
                m_tready <= 1'b0;
                repeat (CHOKE_CYCLES) @(posedge aclk);
            end else begin
                stall = burst_mode ? 0 : $urandom_range(0, 15);
                if (stall != 0) begin
                    m_tready <= 1'b0;
                    repeat (stall) @(posedge aclk);
                end
            end
            m_tready <= 1'b1;
            @(posedge aclk);
            while (!m_tvalid) @(posedge aclk);
        end
    end

    // Watchdog: far beyond the slowest legal run (every request an init, every
    // strobe and every gap at its longest random stall, plus the hold-off).
    initial begin
        #5_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

[filelist.f]
+incdir+src
src/lcdns_pkg.sv
src/lcdns_front.sv
src/lcdns_queue.sv
src/lcdns_back.sv
src/char_lcd_nibble_sequencer_core.sv
bench/lcd_strobe_checker.sv
bench/char_lcd_nibble_sequencer_core_tb.sv
